// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker file of this block.
// Depends on nothing; each use names its clock and reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define PPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PPT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/ppt_pkg.sv -----
// Shared widths, register indexes and state type of the peak tracker.
// Used by the channel interfaces, the core and its checker.
`default_nettype none

package ppt_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned FRAME_OUT_W = 32;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CH_OUT_W   = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned HW_CH_LIMIT = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_FORMAT  = 4'd1;

  localparam logic [MAG_W-1:0] FLOAT_INF_BITS = 32'h7F80_0000;

  typedef enum logic {
    ST_RUN,
    ST_READ
  } ppt_state_t;

endpackage

`default_nettype wire

// ----- rtl/ppt_in_if.sv -----
// Sample input channel: valid/ready handshake with sample and window end flag.
// Widths come from ppt_pkg.
`default_nettype none

interface ppt_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppt_pkg::SAMPLE_W-1:0]  sample_bits;
  logic                          window_end;

  modport source (output valid, output sample_bits, output window_end, input ready);
  modport sink   (input valid, input sample_bits, input window_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppt_out_if.sv -----
// Result channel: one transaction per channel peak at readout.
// Widths come from ppt_pkg.
`default_nettype none

interface ppt_out_if;
  logic                            valid;
  logic                            ready;
  logic [ppt_pkg::CH_OUT_W-1:0]    channel_index;
  logic [ppt_pkg::MAG_W-1:0]       peak_magnitude;
  logic [ppt_pkg::FRAME_OUT_W-1:0] peak_frame;
  logic                            final_result;

  modport source (output valid, output channel_index, output peak_magnitude,
                  output peak_frame, output final_result, input ready);
  modport sink   (input valid, input channel_index, input peak_magnitude,
                  input peak_frame, input final_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppt_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Widths come from ppt_pkg.
`default_nettype none

interface ppt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ppt_pkg::CFG_IDX_W-1:0]  index;
  logic [ppt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/per_channel_peak_tracker_core.sv -----
// Per-channel peak amplitude tracker: input, result and configuration channels.
// Depends on ppt_pkg and the three channel interfaces.
//
// Usage:
//   Samples arrive on in_ch interleaved over channel_count channels; the
//   channel position advances with each accepted transaction and the frame
//   counter each time the position wraps. One sample is accepted per clock
//   while a window is running. The peak and first-peak frame of each channel
//   live in a memory with a registered read; a sample reads its channel entry
//   on acceptance and writes it back in the next cycle; a repeated channel gets
//   the previous write forwarded. A sample flagged window_end is folded in like
//   any other; then the block reads the channel entries back one per cycle while
//   out_ch takes them and offers one result per channel on out_ch, channel 0
//   first, final_result on the last. The first result passes the update stage,
//   the read register and the output register, and in_ch stays not ready until
//   the final result sits in the output register.
//   If out_ch stalls, the output register holds its transaction and readout
//   pauses. cfg_ch is always ready and must be written only while idle.
//   Reset (rst_n low) clears the window, sets channel_count to 1 and integer
//   format; stored entries are marked empty by per-entry valid bits, so no
//   clearing pass is needed.
`default_nettype none

module per_channel_peak_tracker_core #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned FRAME_BITS   = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ppt_in_if.sink     in_ch,
  ppt_out_if.source  out_ch,
  ppt_cfg_if.sink    cfg_ch
);

  localparam int unsigned LIMIT = (MAX_CHANNELS < ppt_pkg::HW_CH_LIMIT) ?
                                  MAX_CHANNELS : ppt_pkg::HW_CH_LIMIT;
  localparam int unsigned IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam int unsigned LOC_W = (FRAME_BITS < ppt_pkg::FRAME_OUT_W) ?
                                  FRAME_BITS : ppt_pkg::FRAME_OUT_W;
  localparam int unsigned CNT_W = ppt_pkg::CNT_W;
  localparam int unsigned MAG_W = ppt_pkg::MAG_W;

  // Configuration registers.
  logic [CNT_W-1:0] chan_cnt_r;
  logic             float_fmt_r;

  // Window state.
  logic [IDX_W-1:0]      pos_r;
  logic [FRAME_BITS-1:0] frame_r;
  logic [LIMIT-1:0]      entry_vld_r;

  // Peak and location memories.
  logic [MAG_W-1:0] pk_mem  [LIMIT];
  logic [LOC_W-1:0] loc_mem [LIMIT];
  logic [MAG_W-1:0] rd_pk_r;
  logic [LOC_W-1:0] rd_loc_r;
  logic             rd_vld_r;

  // Update stage.
  logic             s2_valid_r;
  logic             s2_last_r;
  logic             s2_ok_r;
  logic [IDX_W-1:0] s2_ch_r;
  logic [MAG_W-1:0] s2_mag_r;
  logic [LOC_W-1:0] s2_frame_r;

  // Forwarding of the previous write-back.
  logic             fw_valid_r;
  logic [IDX_W-1:0] fw_ch_r;
  logic [MAG_W-1:0] fw_pk_r;
  logic [LOC_W-1:0] fw_loc_r;

  // Readout.
  ppt_pkg::ppt_state_t state_r, state_nxt;
  logic [CNT_W-1:0] rd_idx_r;
  logic             pend_r;
  logic [CNT_W-1:0] pend_idx_r;

  logic                          out_valid_r;
  logic [ppt_pkg::CH_OUT_W-1:0]  out_idx_r;
  logic [MAG_W-1:0]              out_pk_r;
  logic [ppt_pkg::FRAME_OUT_W-1:0] out_loc_r;
  logic                          out_final_r;

  logic [CNT_W-1:0] n_act;
  logic [IDX_W-1:0] ch;
  logic [CNT_W-1:0] ch_plus1;
  logic [MAG_W-1:0] in_mag;
  logic             in_ok;
  logic             in_ready;
  logic             in_acc;
  logic             rd_issue;
  logic             rd_last;
  logic             load_out;
  logic [IDX_W-1:0] rd_addr;
  logic [MAG_W-1:0] old_pk;
  logic [LOC_W-1:0] old_loc;
  logic             upd;
  logic [MAG_W-1:0] new_pk;
  logic [LOC_W-1:0] new_loc;
  logic [15:0]      low16;

  // Effective channel count: zero means one, capped at the memory depth.
  always_comb begin
    if (chan_cnt_r == '0) begin
      n_act = CNT_W'(1);
    end else if (chan_cnt_r > CNT_W'(LIMIT)) begin
      n_act = CNT_W'(LIMIT);
    end else begin
      n_act = chan_cnt_r;
    end
  end

  // A position left out of range by a smaller channel count wraps to zero.
  always_comb begin
    if (CNT_W'(pos_r) >= n_act) begin
      ch = '0;
    end else begin
      ch = pos_r;
    end
    ch_plus1 = CNT_W'(ch) + CNT_W'(1);
  end

  always_comb begin
    low16 = in_ch.sample_bits[15:0];
    if (float_fmt_r) begin
      in_mag = {1'b0, in_ch.sample_bits[MAG_W-2:0]};
      in_ok  = (in_mag <= ppt_pkg::FLOAT_INF_BITS);
    end else begin
      in_ok = 1'b1;
      if (low16[15]) begin
        in_mag = MAG_W'(17'h1_0000 - {1'b0, low16});
      end else begin
        in_mag = MAG_W'(low16);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppt_pkg::ST_RUN: begin
        if (s2_valid_r && s2_last_r) begin
          state_nxt = ppt_pkg::ST_READ;
        end
      end
      ppt_pkg::ST_READ: begin
        if (rd_issue && rd_last) begin
          state_nxt = ppt_pkg::ST_RUN;
        end
      end
      default: state_nxt = ppt_pkg::ST_RUN;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    rd_issue = 1'b0;
    case (state_r)
      ppt_pkg::ST_RUN: begin
        in_ready = !pend_r && !(s2_valid_r && s2_last_r);
      end
      ppt_pkg::ST_READ: begin
        rd_issue = !pend_r || load_out;
      end
      default: begin
        in_ready = 1'b0;
        rd_issue = 1'b0;
      end
    endcase
  end

  assign load_out = pend_r && (!out_valid_r || out_ch.ready);
  assign rd_last  = (rd_idx_r + CNT_W'(1)) == n_act;
  assign in_acc   = in_ch.valid && in_ready;
  assign rd_addr  = (state_r == ppt_pkg::ST_READ) ? rd_idx_r[IDX_W-1:0] : ch;

  // Read-modify-write resolution, with the previous write forwarded.
  always_comb begin
    if (fw_valid_r && (fw_ch_r == s2_ch_r)) begin
      old_pk  = fw_pk_r;
      old_loc = fw_loc_r;
    end else if (rd_vld_r) begin
      old_pk  = rd_pk_r;
      old_loc = rd_loc_r;
    end else begin
      old_pk  = '0;
      old_loc = '0;
    end
    upd     = s2_ok_r && (s2_mag_r > old_pk);
    new_pk  = upd ? s2_mag_r : old_pk;
    new_loc = upd ? s2_frame_r : old_loc;
  end

  // Memories: one read port, one write port.
  always_ff @(posedge clk) begin
    if (in_acc || rd_issue) begin
      rd_pk_r  <= pk_mem[rd_addr];
      rd_loc_r <= loc_mem[rd_addr];
    end
    if (s2_valid_r) begin
      pk_mem[s2_ch_r]  <= new_pk;
      loc_mem[s2_ch_r] <= new_loc;
    end
  end

  always_ff @(posedge clk) begin
    s2_ch_r    <= ch;
    s2_mag_r   <= in_mag;
    s2_ok_r    <= in_ok;
    s2_last_r  <= in_ch.window_end;
    s2_frame_r <= frame_r[LOC_W-1:0];
    fw_ch_r    <= s2_ch_r;
    fw_pk_r    <= new_pk;
    fw_loc_r   <= new_loc;
    if (rd_issue) begin
      pend_idx_r <= rd_idx_r;
    end
    if (load_out) begin
      out_idx_r   <= ppt_pkg::CH_OUT_W'(pend_idx_r);
      out_pk_r    <= rd_vld_r ? rd_pk_r : '0;
      out_loc_r   <= rd_vld_r ? ppt_pkg::FRAME_OUT_W'(rd_loc_r) : '0;
      out_final_r <= (pend_idx_r + CNT_W'(1)) == n_act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r  <= CNT_W'(1);
      float_fmt_r <= 1'b0;
      pos_r       <= '0;
      frame_r     <= '0;
      entry_vld_r <= '0;
      rd_vld_r    <= 1'b0;
      s2_valid_r  <= 1'b0;
      fw_valid_r  <= 1'b0;
      state_r     <= ppt_pkg::ST_RUN;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s2_valid_r <= in_acc;
      fw_valid_r <= s2_valid_r;

      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          ppt_pkg::REG_CHANNEL_COUNT: chan_cnt_r  <= cfg_ch.data[CNT_W-1:0];
          ppt_pkg::REG_FLOAT_FORMAT:  float_fmt_r <= cfg_ch.data[0];
          default: ;
        endcase
      end

      if (in_acc || rd_issue) begin
        rd_vld_r <= entry_vld_r[rd_addr];
      end

      if (in_acc) begin
        if (ch_plus1 >= n_act) begin
          pos_r <= '0;
          if (frame_r != '1) begin
            frame_r <= frame_r + FRAME_BITS'(1);
          end
        end else begin
          pos_r <= ch_plus1[IDX_W-1:0];
        end
      end

      if (s2_valid_r) begin
        entry_vld_r[s2_ch_r] <= 1'b1;
      end

      if (s2_valid_r && s2_last_r) begin
        rd_idx_r <= '0;
      end else if (rd_issue) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end

      // The last readout request closes the window.
      if (rd_issue && rd_last) begin
        entry_vld_r <= '0;
        pos_r       <= '0;
        frame_r     <= '0;
      end

      if (rd_issue) begin
        pend_r <= 1'b1;
      end else if (load_out) begin
        pend_r <= 1'b0;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready          = in_ready;
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.channel_index = out_idx_r;
  assign out_ch.peak_magnitude = out_pk_r;
  assign out_ch.peak_frame    = out_loc_r;
  assign out_ch.final_result  = out_final_r;

endmodule

`default_nettype wire

// ----- rtl/ppt_checker.sv -----
// Port-level checker for the peak tracker core, attached by bind below.
// Depends on ppt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ppt_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [ppt_pkg::CH_OUT_W-1:0]    out_channel_index,
  input wire logic [ppt_pkg::MAG_W-1:0]       out_peak_magnitude,
  input wire logic [ppt_pkg::FRAME_OUT_W-1:0] out_peak_frame,
  input wire logic                            out_final_result
);

  logic                         out_acc;
  logic [ppt_pkg::CH_OUT_W-1:0] exp_idx_r;

  assign out_acc = out_valid && out_ready;

  // Results of one readout run through the channels in ascending order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_acc) begin
      exp_idx_r <= out_final_result ? '0 : out_channel_index + ppt_pkg::CH_OUT_W'(1);
    end
  end

  `PPT_ASSERT(a_out_hold, clk, rst_n,
              out_valid && !out_ready |=> out_valid && $stable(out_channel_index) &&
              $stable(out_peak_magnitude) && $stable(out_peak_frame) &&
              $stable(out_final_result),
              "stalled result transaction changed")
  `PPT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid,
                     "result valid straight after reset")
  `PPT_ASSERT(a_idx_order, clk, rst_n, out_acc |-> out_channel_index == exp_idx_r,
              "result channel out of order")
  `PPT_ASSERT(a_no_input_in_readout, clk, rst_n, out_acc && !out_final_result |-> !in_ready,
              "input accepted during readout")

endmodule

bind per_channel_peak_tracker_core ppt_checker u_ppt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_channel_index  (out_ch.channel_index),
  .out_peak_magnitude (out_ch.peak_magnitude),
  .out_peak_frame     (out_ch.peak_frame),
  .out_final_result   (out_ch.final_result)
);

`default_nettype wire
